/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication property, sampled on clk, off while in reset
`define SOPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define SOPS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* design/sops_pkg.sv */
`default_nettype none

package sops_pkg;

	localparam int INIT_END = 6;
	localparam int INIT_LEN = 4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQRT,
		ST_FILL,
		ST_A_RD,
		ST_A_WAIT,
		ST_MUL,
		ST_DIV,
		ST_FIRST,
		ST_FIRST2,
		ST_MARK,
		ST_B_RD,
		ST_B_WAIT,
		ST_C_SCAN,
		ST_SEG_DONE,
		ST_RD,
		ST_RD_WAIT,
		ST_OUT
	} sops_state_t;

	// table entries 0..3 after reset
	function automatic logic [7:0] init_prime(input logic [1:0] sel);
		logic [7:0] v;
		unique case (sel)
			2'd0: v = 8'd1;
			2'd1: v = 8'd2;
			2'd2: v = 8'd3;
			default: v = 8'd5;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/segmented_odd_prime_sieve.sv */
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: last_index[15:0]
// m_*      out  tdata: next_index[15:0], prime_value[47:16], status[48], zero pad
//
// A request that hits the stored table is read out directly. A miss sieves one or
// more segments: the bitmap is refilled, survivors are appended, and each sieving
// prime first takes a setup (square, bit-serial divide, first multiple) before its
// multiples are struck.
// After reset, entries 0..3 read as 1,2,3,5 from constants; no clearing pass is needed.
// A new request is taken while the previous result waits on m_tready.
`default_nettype none
`include "assert_macros.svh"

module segmented_odd_prime_sieve import sops_pkg::*; #(
	parameter int SEG_BITS    = 32768,
	parameter int TABLE_DEPTH = 65536,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // last_index[15:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata   // next_index, prime_value, status, pad
);

	localparam int SB  = $clog2(SEG_BITS);
	localparam int TW  = $clog2(TABLE_DEPTH);
	localparam int LW  = TW + 1;
	localparam int HW  = (VALUE_BITS + 1) / 2;
	localparam int VB  = VALUE_BITS;
	localparam int XW  = (VB > 22 ? VB : 22) + 3;
	localparam int CW  = (LW > 17 ? LW : 17);
	localparam int MW  = (SB > HW ? SB : HW) + 2;
	localparam int SCW = $clog2(HW + 1);
	localparam int DCW = $clog2(VB + 1);

	sops_state_t state_q, state_d;

	// memories
	logic [VB-1:0] tbl_mem [TABLE_DEPTH];
	logic          bm_mem  [SEG_BITS];

	logic          tbl_we;
	logic [TW-1:0] tbl_waddr, tbl_raddr;
	logic [VB-1:0] tbl_wdata, tbl_dout_q, tbl_val;
	logic          tbl_lo_q;
	logic [1:0]    tbl_sel_q;

	logic          bm_we, bm_wdata, bm_dout_q;
	logic [SB-1:0] bm_waddr, bm_raddr;

	// state and datapath registers
	logic [16:0]     idx_q;
	logic [LW-1:0]   len_q;
	logic [VB-1:0]   seg_end_q, start_q, end_q;
	logic [2*HW-1:0] sq_v_q, sq_pp_q;
	logic [HW-1:0]   sq_res_q, p_q, div_rem_q;
	logic [HW:0]     sq_rem_q;
	logic [SCW-1:0]  sq_cnt_q;
	logic [VB-1:0]   div_v_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [SB-1:0]   fill_q, c_i_s1;
	logic            c_v_s1;
	logic [LW-1:0]   k_q;
	logic [SB:0]     i_q;
	logic [XW-1:0]   q_q;
	logic [MW-1:0]   mi_q;
	logic            ret_b_q, fail_q;
	logic [31:0]     val_q;
	logic            m_tvalid_q;
	logic [55:0]     m_tdata_q;

	// combinational helpers
	logic            need_seg, fail_c, out_free;
	logic [XW-1:0]   p_b, qq, off;
	logic [HW+2:0]   sq_rn, sq_trial;
	logic [HW:0]     div_rn;
	logic            b_hit;

	assign tbl_val  = tbl_lo_q ? VB'(init_prime(tbl_sel_q)) : tbl_dout_q;
	assign need_seg = CW'(idx_q) >= CW'(len_q);
	assign fail_c   = (len_q >= LW'(TABLE_DEPTH)) ||
		((XW'({VB{1'b1}}) - XW'(seg_end_q)) < XW'(2 * SEG_BITS));
	assign p_b      = XW'(start_q) + XW'({i_q, 1'b0});
	assign qq       = q_q + (q_q[0] ? XW'(0) : XW'(p_q));
	assign off      = qq - XW'(start_q);
	assign sq_rn    = {sq_rem_q, sq_v_q[2*HW-1 -: 2]};
	assign sq_trial = (HW+3)'({sq_res_q, 2'b01});
	assign div_rn   = {div_rem_q, div_v_q[VB-1]};
	assign b_hit    = c_v_s1 && bm_dout_q && (len_q < LW'(TABLE_DEPTH));
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		tbl_dout_q <= tbl_mem[tbl_raddr];
		tbl_lo_q   <= (tbl_raddr < TW'(INIT_LEN));
		tbl_sel_q  <= tbl_raddr[1:0];
	end

	always_ff @(posedge clk) begin
		if (bm_we)
			bm_mem[bm_waddr] <= bm_wdata;
		bm_dout_q <= bm_mem[bm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		tbl_we    = 1'b0;
		tbl_waddr = len_q[TW-1:0];
		tbl_wdata = VB'(XW'(start_q) + XW'({c_i_s1, 1'b0}));
		tbl_raddr = k_q[TW-1:0];
		bm_we     = 1'b0;
		bm_waddr  = fill_q;
		bm_wdata  = 1'b1;
		bm_raddr  = i_q[SB-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!need_seg)
					state_d = ST_RD;
				else if (fail_c)
					state_d = ST_OUT;
				else
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_cnt_q == SCW'(HW - 1))
					state_d = ST_FILL;
			end
			ST_FILL: begin
				bm_we = 1'b1;
				if (fill_q == SB'(SEG_BITS - 1))
					state_d = ST_A_RD;
			end
			ST_A_RD: begin
				if (k_q >= len_q)
					state_d = ST_B_RD;
				else
					state_d = ST_A_WAIT;
			end
			ST_A_WAIT: begin
				if (tbl_val > VB'(sq_res_q))
					state_d = ST_B_RD;
				else
					state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCW'(VB - 1))
					state_d = ST_FIRST;
			end
			ST_FIRST: state_d = ST_FIRST2;
			ST_FIRST2: begin
				if (off > XW'(2 * SEG_BITS - 2))
					state_d = ret_b_q ? ST_B_RD : ST_A_RD;
				else
					state_d = ST_MARK;
			end
			ST_MARK: begin
				if (mi_q < MW'(SEG_BITS)) begin
					bm_we    = 1'b1;
					bm_waddr = mi_q[SB-1:0];
					bm_wdata = 1'b0;
				end else begin
					state_d = ret_b_q ? ST_B_RD : ST_A_RD;
				end
			end
			ST_B_RD: begin
				if (i_q == (SB+1)'(SEG_BITS))
					state_d = ST_C_SCAN;
				else
					state_d = ST_B_WAIT;
			end
			ST_B_WAIT: begin
				if (!bm_dout_q)
					state_d = ST_B_RD;
				else if (p_b > XW'(sq_res_q))
					state_d = ST_C_SCAN;
				else
					state_d = ST_MUL;
			end
			ST_C_SCAN: begin
				tbl_we = b_hit;
				if (i_q == (SB+1)'(SEG_BITS) && !c_v_s1)
					state_d = ST_SEG_DONE;
			end
			ST_SEG_DONE: state_d = ST_CHECK;
			ST_RD: begin
				tbl_raddr = idx_q[TW-1:0];
				state_d   = ST_RD_WAIT;
			end
			ST_RD_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= LW'(INIT_LEN);
			seg_end_q  <= VB'(INIT_END);
			m_tvalid_q <= 1'b0;
			c_v_s1     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (state_q == ST_OUT && out_free)
				m_tvalid_q <= 1'b1;
			if (state_q == ST_C_SCAN && b_hit)
				len_q <= len_q + LW'(1);
			if (state_q == ST_SEG_DONE)
				seg_end_q <= end_q;
			c_v_s1 <= (state_q == ST_C_SCAN) && (i_q < (SB+1)'(SEG_BITS));
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		c_i_s1 <= i_q[SB-1:0];
		unique case (state_q)
			ST_IDLE: begin
				idx_q  <= {1'b0, s_tdata} + 17'd1;
				fail_q <= 1'b0;
			end
			ST_CHECK: begin
				fail_q    <= need_seg && fail_c;
				start_q   <= seg_end_q + VB'(1);
				end_q     <= VB'(XW'(seg_end_q) + XW'(2 * SEG_BITS));
				sq_v_q    <= (2*HW)'(XW'(seg_end_q) + XW'(2 * SEG_BITS));
				sq_res_q  <= '0;
				sq_rem_q  <= '0;
				sq_cnt_q  <= '0;
				fill_q    <= '0;
			end
			ST_SQRT: begin
				sq_v_q   <= {sq_v_q[2*HW-3:0], 2'b00};
				sq_cnt_q <= sq_cnt_q + SCW'(1);
				if (sq_rn >= sq_trial) begin
					sq_rem_q <= (HW+1)'(sq_rn - sq_trial);
					sq_res_q <= {sq_res_q[HW-2:0], 1'b1};
				end else begin
					sq_rem_q <= sq_rn[HW:0];
					sq_res_q <= {sq_res_q[HW-2:0], 1'b0};
				end
			end
			ST_FILL: begin
				fill_q <= fill_q + SB'(1);
				k_q    <= LW'(2);
			end
			ST_A_RD: begin
				i_q <= '0;
			end
			ST_A_WAIT: begin
				p_q     <= tbl_val[HW-1:0];
				ret_b_q <= 1'b0;
			end
			ST_MUL: begin
				sq_pp_q   <= (2*HW)'(p_q * p_q);
				div_v_q   <= start_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				div_v_q   <= {div_v_q[VB-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (div_rn >= {1'b0, p_q})
					div_rem_q <= HW'(div_rn - {1'b0, p_q});
				else
					div_rem_q <= div_rn[HW-1:0];
			end
			ST_FIRST: begin
				if (XW'(sq_pp_q) >= XW'(start_q))
					q_q <= XW'(sq_pp_q);
				else if (div_rem_q != '0)
					q_q <= XW'(start_q) + XW'(p_q - div_rem_q);
				else
					q_q <= XW'(start_q);
			end
			ST_FIRST2: begin
				mi_q <= MW'(off >> 1);
				if (off > XW'(2 * SEG_BITS - 2)) begin
					if (ret_b_q)
						i_q <= i_q + (SB+1)'(1);
					else
						k_q <= k_q + LW'(1);
				end
			end
			ST_MARK: begin
				mi_q <= mi_q + MW'(p_q);
				if (mi_q >= MW'(SEG_BITS)) begin
					if (ret_b_q)
						i_q <= i_q + (SB+1)'(1);
					else
						k_q <= k_q + LW'(1);
				end
			end
			ST_B_RD: begin
				if (i_q == (SB+1)'(SEG_BITS))
					i_q <= '0;
			end
			ST_B_WAIT: begin
				p_q     <= p_b[HW-1:0];
				ret_b_q <= 1'b1;
				if (!bm_dout_q)
					i_q <= i_q + (SB+1)'(1);
				else if (p_b > XW'(sq_res_q))
					i_q <= '0;
			end
			ST_C_SCAN: begin
				if (i_q < (SB+1)'(SEG_BITS))
					i_q <= i_q + (SB+1)'(1);
			end
			ST_RD_WAIT: begin
				val_q <= 32'(tbl_val);
			end
			ST_OUT: begin
				if (out_free)
					m_tdata_q <= {7'd0, fail_q, (fail_q ? 32'd0 : val_q), idx_q[15:0]};
			end
			default: begin
			end
		endcase
	end

	// table only grows, and appends never touch the preloaded entries
	`SOPS_ASSERT(a_len_grows, (state_q != ST_IDLE) |=> (len_q >= $past(len_q)), "table length shrank")
	`SOPS_NEVER(a_wr_low, tbl_we && (len_q < LW'(INIT_LEN)), "write into preloaded entries")
	`SOPS_ASSERT(a_fail_zero, (m_tvalid && m_tdata[48]) |-> (m_tdata[47:16] == 32'd0), "failed result carries a value")
	`SOPS_NEVER(a_one_port, tbl_we && (state_q != ST_C_SCAN), "table write outside append scan")

endmodule

`default_nettype wire
